@@ src/mnc_pkg.sv @@
// ----------------------------------------------------------------------------
// mnc_pkg
// Shared types and codes for the mail notification client state machine.
// ----------------------------------------------------------------------------
package mnc_pkg;

    // Default length of the protocol time unit in seconds.
    localparam int unsigned UNIT_SECONDS_DEF = 180;

    // Commands carried by an input transaction.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_PACKET = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;
    localparam logic [1:0] CMD_END    = 2'd3;

    // Decoded kinds of received packets.
    localparam logic [2:0] PKT_QUIT_HUP   = 3'd0;
    localparam logic [2:0] PKT_QUIT       = 3'd1;
    localparam logic [2:0] PKT_REGISTERED = 3'd2;
    localparam logic [2:0] PKT_REFUSED    = 3'd3;
    localparam logic [2:0] PKT_STATUS     = 3'd4;
    localparam logic [2:0] PKT_BAD_STATUS = 3'd5;

    // Packets to send.
    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_REQ  = 2'd1;
    localparam logic [1:0] SEND_KEEP = 2'd2;
    localparam logic [1:0] SEND_QUIT = 2'd3;

    // Link states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_HUP     = 3'd1;
    localparam logic [2:0] ST_WAITREG = 3'd2;
    localparam logic [2:0] ST_CONN    = 3'd3;
    localparam logic [2:0] ST_STATUS  = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  packet_kind;
        logic [15:0] interval_secs;
        logic [31:0] box_size;
        logic [31:0] box_date;
        logic [15:0] random_value;
    } evt_item_t;

    typedef struct packed {
        logic [1:0] send_kind;
        logic       mail_present;
        logic       new_mail_bell;
        logic [2:0] link_state;
        logic       timer_running;
    } res_item_t;

endpackage

@@ src/mail_notify_client_fsm.sv @@
// ----------------------------------------------------------------------------
// mail_notify_client_fsm
// Client side of a UDP mail notification keep-alive protocol, one event per
// transaction, one result transaction per event.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload            | Role
//  --------+----------------------+--------------------+---------------------
//  evt     | evt_valid/evt_ready  | evt_data (evt_item_t) | tick, packet, start, end
//  res     | res_valid/res_ready  | res_data (res_item_t) | packet to send, status
//
// An event transaction is held in the input register, where the
// quotient estimates for the two random backoff remainders are already
// registered, and is then resolved against the protocol state in a single
// pass into the result register. Throughput is one transaction per cycle
// while res is not stalled. The rate is set by the protocol state update,
// which is a single combinational pass.
// Reset (rst_n low, asynchronous) clears the link state, timers, mailbox
// history and both pipeline valid flags. A stall on res holds the result
// register and then the input register; evt_ready falls only when both are full.
// ----------------------------------------------------------------------------
module mail_notify_client_fsm
    import mnc_pkg::*;
#(
    parameter int unsigned UNIT_SECONDS = UNIT_SECONDS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      evt_valid,
    output logic      evt_ready,
    input  evt_item_t evt_data,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_data
);

    // Divisors for the two randomized waits and their reciprocals, scaled by
    // two to the 32nd power. The smaller divisor is at least two for any
    // legal time unit, so both reciprocals fit in 32 bits.
    localparam int unsigned DIV_SHORT_INT = UNIT_SECONDS * 2 / 3;
    localparam logic [15:0] DIV_LONG      = 16'(UNIT_SECONDS);
    localparam logic [15:0] DIV_SHORT     = 16'(DIV_SHORT_INT);
    localparam logic [31:0] RECIP_LONG    = 32'((64'd1 << 32) / UNIT_SECONDS);
    localparam logic [31:0] RECIP_SHORT   = 32'((64'd1 << 32) / DIV_SHORT_INT);
    localparam logic [15:0] WAIT_REQ      = 16'(UNIT_SECONDS);
    localparam logic [15:0] WAIT_BACKOFF  = 16'(2 * UNIT_SECONDS);
    localparam logic [15:0] STATUS_LIMIT  = 16'(5 * UNIT_SECONDS);

    // Input register.
    logic        stg_valid_reg;
    evt_item_t   stg_item_reg;
    logic [15:0] stg_qlong_reg;
    logic [15:0] stg_qshort_reg;

    // Result register.
    logic        res_valid_reg;
    res_item_t   res_item_reg;

    // Protocol state.
    logic [2:0]  proto_state_reg, proto_state_next;
    logic [15:0] wait_left_reg, wait_left_next;
    logic        wait_active_reg, wait_active_next;
    logic [15:0] since_status_reg, since_status_next;
    logic [15:0] server_interval_reg, server_interval_next;
    logic [31:0] prev_size_reg, prev_size_next;
    logic [31:0] prev_date_reg, prev_date_next;
    logic        mail_flag_reg, mail_flag_next;
    logic [1:0]  send_next;
    logic        bell_next;

    logic        advance;
    logic [47:0] prod_long;
    logic [47:0] prod_short;
    logic [15:0] rem_long;
    logic [15:0] rem_short;
    logic [15:0] rest_long;
    logic [15:0] rest_short;
    logic [15:0] backoff_long;

    // Handshake: the input register moves on whenever the result register is
    // empty or being emptied in this cycle.
    assign advance   = stg_valid_reg && (!res_valid_reg || res_ready);
    assign evt_ready = !stg_valid_reg || advance;
    assign res_valid = res_valid_reg;
    assign res_data  = res_item_reg;

    // Quotient estimates from reciprocal multiplication, taken at the input.
    // Each estimate is the true quotient or one less.
    assign prod_long  = 48'(evt_data.random_value) * 48'(RECIP_LONG);
    assign prod_short = 48'(evt_data.random_value) * 48'(RECIP_SHORT);

    // Remainders: subtract the quotient times the divisor and correct once.
    always_comb
    begin
        rest_long  = stg_item_reg.random_value - 16'(32'(stg_qlong_reg) * 32'(DIV_LONG));
        rest_short = stg_item_reg.random_value
                   - 16'(32'(stg_qshort_reg) * 32'(DIV_SHORT));
        rem_long   = (rest_long >= DIV_LONG) ? (rest_long - DIV_LONG) : rest_long;
        rem_short  = (rest_short >= DIV_SHORT) ? (rest_short - DIV_SHORT) : rest_short;
        backoff_long = WAIT_BACKOFF + rem_long;
    end

    // One pass of the protocol for the transaction in the input register.
    always_comb
    begin
        logic        watched;
        logic [15:0] limit;
        logic [15:0] since_inc;
        logic [15:0] wait_dec;
        logic        is_status;
        logic        valid_status;

        proto_state_next     = proto_state_reg;
        wait_left_next       = wait_left_reg;
        wait_active_next     = wait_active_reg;
        since_status_next    = since_status_reg;
        server_interval_next = server_interval_reg;
        prev_size_next       = prev_size_reg;
        prev_date_next       = prev_date_reg;
        mail_flag_next       = mail_flag_reg;
        send_next            = SEND_NONE;
        bell_next            = 1'b0;

        watched   = (proto_state_reg == ST_CONN) || (proto_state_reg == ST_STATUS);
        limit     = (proto_state_reg == ST_CONN) ? server_interval_reg : STATUS_LIMIT;
        since_inc = (since_status_reg == 16'hFFFF) ? since_status_reg
                                                   : since_status_reg + 16'd1;
        wait_dec  = (wait_left_reg == 16'd0) ? wait_left_reg : wait_left_reg - 16'd1;
        is_status    = (stg_item_reg.packet_kind == PKT_STATUS)
                    || (stg_item_reg.packet_kind == PKT_BAD_STATUS);
        valid_status = stg_item_reg.packet_kind == PKT_STATUS;

        case (stg_item_reg.command)
            CMD_TICK:
            begin
                since_status_next = since_inc;
                if (watched && since_inc >= limit)
                begin
                    // Watchdog: no status for too long, register again.
                    send_next        = SEND_REQ;
                    proto_state_next = ST_WAITREG;
                    wait_left_next   = WAIT_REQ;
                    wait_active_next = 1'b1;
                end
                else if (wait_active_reg)
                begin
                    wait_left_next = wait_dec;
                    if (wait_dec == 16'd0)
                    begin
                        case (proto_state_reg)
                            ST_HUP, ST_WAITREG, ST_CONN:
                            begin
                                send_next        = SEND_REQ;
                                proto_state_next = ST_WAITREG;
                                wait_left_next   = WAIT_REQ;
                                wait_active_next = 1'b1;
                            end
                            ST_STATUS:
                            begin
                                send_next         = SEND_KEEP;
                                proto_state_next  = ST_CONN;
                                wait_left_next    = server_interval_reg;
                                wait_active_next  = 1'b1;
                                since_status_next = 16'd0;
                            end
                            default:
                            begin
                                wait_active_next = 1'b0;
                            end
                        endcase
                    end
                end
            end
            CMD_PACKET:
            begin
                if (stg_item_reg.packet_kind == PKT_QUIT_HUP)
                begin
                    proto_state_next = ST_HUP;
                    wait_left_next   = backoff_long;
                    wait_active_next = 1'b1;
                    mail_flag_next   = 1'b0;
                end
                else if (stg_item_reg.packet_kind == PKT_QUIT)
                begin
                    proto_state_next = ST_IDLE;
                    wait_active_next = 1'b0;
                    mail_flag_next   = 1'b0;
                end
                else
                begin
                    if (is_status && valid_status
                        && (proto_state_reg == ST_CONN || proto_state_reg == ST_STATUS))
                    begin
                        bell_next = (stg_item_reg.box_size > prev_size_reg)
                                 || (stg_item_reg.box_size != 32'd0
                                     && stg_item_reg.box_date > prev_date_reg);
                        mail_flag_next = stg_item_reg.box_size != 32'd0;
                        prev_size_next = stg_item_reg.box_size;
                        prev_date_next = stg_item_reg.box_date;
                    end
                    case (proto_state_reg)
                        ST_WAITREG:
                        begin
                            if (stg_item_reg.packet_kind == PKT_REGISTERED)
                            begin
                                server_interval_next = stg_item_reg.interval_secs;
                                proto_state_next     = ST_CONN;
                                wait_left_next       = backoff_long;
                                wait_active_next     = 1'b1;
                                since_status_next    = 16'd0;
                            end
                            else if (stg_item_reg.packet_kind == PKT_REFUSED)
                            begin
                                proto_state_next = ST_IDLE;
                            end
                        end
                        ST_CONN:
                        begin
                            if (is_status)
                            begin
                                if (valid_status)
                                begin
                                    since_status_next = 16'd0;
                                end
                                proto_state_next = ST_STATUS;
                                wait_left_next   = rem_short;
                                wait_active_next = 1'b1;
                            end
                        end
                        ST_STATUS:
                        begin
                            if (is_status)
                            begin
                                send_next         = SEND_KEEP;
                                proto_state_next  = ST_CONN;
                                wait_left_next    = server_interval_reg;
                                wait_active_next  = 1'b1;
                                since_status_next = 16'd0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            CMD_START:
            begin
                send_next        = SEND_REQ;
                proto_state_next = ST_WAITREG;
                wait_left_next   = WAIT_REQ;
                wait_active_next = 1'b1;
            end
            default:
            begin
                if (proto_state_reg == ST_CONN || proto_state_reg == ST_STATUS)
                begin
                    send_next = SEND_QUIT;
                end
                proto_state_next = ST_IDLE;
                mail_flag_next   = 1'b0;
                wait_active_next = 1'b0;
            end
        endcase
    end

    // Control and protocol state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg       <= 1'b0;
            res_valid_reg       <= 1'b0;
            proto_state_reg     <= ST_IDLE;
            wait_left_reg       <= 16'd0;
            wait_active_reg     <= 1'b0;
            since_status_reg    <= 16'd0;
            server_interval_reg <= 16'd0;
            prev_size_reg       <= 32'd0;
            prev_date_reg       <= 32'd0;
            mail_flag_reg       <= 1'b0;
        end
        else
        begin
            if (evt_ready)
            begin
                stg_valid_reg <= evt_valid;
            end
            if (advance)
            begin
                res_valid_reg       <= 1'b1;
                proto_state_reg     <= proto_state_next;
                wait_left_reg       <= wait_left_next;
                wait_active_reg     <= wait_active_next;
                since_status_reg    <= since_status_next;
                server_interval_reg <= server_interval_next;
                prev_size_reg       <= prev_size_next;
                prev_date_reg       <= prev_date_next;
                mail_flag_reg       <= mail_flag_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (evt_ready && evt_valid)
        begin
            stg_item_reg   <= evt_data;
            stg_qlong_reg  <= prod_long[47:32];
            stg_qshort_reg <= prod_short[47:32];
        end
        if (advance)
        begin
            res_item_reg.send_kind     <= send_next;
            res_item_reg.mail_present  <= mail_flag_next;
            res_item_reg.new_mail_bell <= bell_next;
            res_item_reg.link_state    <= proto_state_next;
            res_item_reg.timer_running <= wait_active_next;
        end
    end

`ifndef ASSERT_OFF
    // An end command always leaves the link idle with the timer stopped.
    a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stg_item_reg.command == CMD_END
        |=> res_item_reg.link_state == ST_IDLE && !res_item_reg.timer_running)
        else $error("end command did not stop the link");

    // A bell can only ring when the mailbox is reported nonempty.
    a_bell_has_mail: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_item_reg.new_mail_bell |-> res_item_reg.mail_present)
        else $error("bell without mail");

    // A request always waits for registration with the timer running.
    a_req_waits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_item_reg.send_kind == SEND_REQ
        |-> res_item_reg.link_state == ST_WAITREG && res_item_reg.timer_running)
        else $error("request sent outside registration wait");

    // A keep-alive always lands in the connected state.
    a_keep_conn: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_item_reg.send_kind == SEND_KEEP
        |-> res_item_reg.link_state == ST_CONN && res_item_reg.timer_running)
        else $error("keep-alive outside connected state");

    // The result register is reported exactly as the state was left.
    a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_item_reg.link_state == proto_state_reg
                 && res_item_reg.timer_running == wait_active_reg)
        else $error("result does not match protocol state");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mail notification client state machine. A
// clocked driver feeds event transactions from a queue of pending events, and
// a behavioral model of the client predicts each result. A clocked monitor
// compares every result transaction with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module testbench;

    import mnc_pkg::*;

    // Time unit of the protocol. The bench runs the block at its default.
    localparam int unsigned UNIT = UNIT_SECONDS_DEF;

    // Packet kinds that the package leaves unnamed. The block ignores both.
    localparam logic [2:0] PKT_OTHER     = 3'd6;
    localparam logic [2:0] PKT_UNDEFINED = 3'd7;

    // Size of the random part, in event transactions.
    localparam int RANDOM_EVENTS = 1850;

    // Idle cycles with no transaction on either channel before the run is
    // declared hung. The longest legal pause is a send gap plus a receive
    // stall plus the trip through the input and result registers.
    localparam int STALL_LIMIT = 5000;

    // Cycles to keep watching the result channel once nothing is awaited.
    localparam int DRAIN_CYCLES = 10;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      evt_valid = 1'b0;
    logic      evt_ready;
    evt_item_t evt_data  = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    res_item_t res_data;

    mail_notify_client_fsm #(
        .UNIT_SECONDS (UNIT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_data  (evt_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral model of the client. It keeps its own copy of the protocol
    // state and is stepped once for every event transaction that the block
    // accepts, in acceptance order.
    // ------------------------------------------------------------------------
    logic [2:0]  lnk_state;
    logic [15:0] countdown;
    logic        countdown_on;
    logic [15:0] secs_since_status;
    logic [15:0] keepalive_ivl;
    logic [31:0] last_box_size;
    logic [31:0] last_box_date;
    logic        mail_waiting;
    res_item_t   predicted;

    // Arming the countdown always turns the timer on, even for a zero wait.
    function automatic void start_countdown(input int unsigned secs);
        countdown    = secs[15:0];
        countdown_on = 1'b1;
    endfunction

    function automatic void issue_request();
        predicted.send_kind = SEND_REQ;
        lnk_state = ST_WAITREG;
        start_countdown(UNIT);
    endfunction

    function automatic void issue_keepalive();
        predicted.send_kind = SEND_KEEP;
        lnk_state = ST_CONN;
        start_countdown(32'(keepalive_ivl));
        secs_since_status = '0;
    endfunction

    // New mail means a bigger mailbox, or a nonempty one with a newer date.
    function automatic void absorb_status(input logic [31:0] size, input logic [31:0] date);
        if (size > last_box_size || (size != 0 && date > last_box_date))
            predicted.new_mail_bell = 1'b1;
        mail_waiting  = (size != 0);
        last_box_size = size;
        last_box_date = date;
    endfunction

    function automatic res_item_t client_step(input evt_item_t ev);
        predicted = '0;
        predicted.send_kind = SEND_NONE;
        case (ev.command)
            CMD_TICK:
            begin
                if (secs_since_status != 16'hFFFF)
                    secs_since_status = secs_since_status + 16'd1;
                // The keep-alive watchdog is looked at before the countdown.
                if (lnk_state == ST_CONN && secs_since_status >= keepalive_ivl)
                    issue_request();
                else if (lnk_state == ST_STATUS && secs_since_status >= 16'(5 * UNIT))
                    issue_request();
                else if (countdown_on)
                begin
                    if (countdown != 0)
                        countdown = countdown - 16'd1;
                    if (countdown == 0)
                    begin
                        case (lnk_state)
                            ST_HUP, ST_WAITREG, ST_CONN: issue_request();
                            ST_STATUS:                   issue_keepalive();
                            default:                     countdown_on = 1'b0;
                        endcase
                    end
                end
            end
            CMD_PACKET:
            begin
                if (ev.packet_kind == PKT_QUIT_HUP)
                begin
                    lnk_state = ST_HUP;
                    start_countdown(2 * UNIT + ev.random_value % UNIT);
                    mail_waiting = 1'b0;
                end
                else if (ev.packet_kind == PKT_QUIT)
                begin
                    lnk_state    = ST_IDLE;
                    countdown_on = 1'b0;
                    mail_waiting = 1'b0;
                end
                else if (lnk_state == ST_WAITREG)
                begin
                    if (ev.packet_kind == PKT_REGISTERED)
                    begin
                        keepalive_ivl = ev.interval_secs;
                        lnk_state = ST_CONN;
                        start_countdown(2 * UNIT + ev.random_value % UNIT);
                        secs_since_status = '0;
                    end
                    else if (ev.packet_kind == PKT_REFUSED)
                        lnk_state = ST_IDLE;
                end
                else if (lnk_state == ST_CONN)
                begin
                    if (ev.packet_kind == PKT_STATUS || ev.packet_kind == PKT_BAD_STATUS)
                    begin
                        if (ev.packet_kind == PKT_STATUS)
                        begin
                            absorb_status(ev.box_size, ev.box_date);
                            secs_since_status = '0;
                        end
                        lnk_state = ST_STATUS;
                        start_countdown(ev.random_value % (UNIT * 2 / 3));
                    end
                end
                else if (lnk_state == ST_STATUS)
                begin
                    if (ev.packet_kind == PKT_STATUS || ev.packet_kind == PKT_BAD_STATUS)
                    begin
                        if (ev.packet_kind == PKT_STATUS)
                            absorb_status(ev.box_size, ev.box_date);
                        issue_keepalive();
                    end
                end
            end
            CMD_START:
                issue_request();
            default:
            begin
                // End of service says goodbye only on a live link.
                if (lnk_state == ST_CONN || lnk_state == ST_STATUS)
                    predicted.send_kind = SEND_QUIT;
                lnk_state    = ST_IDLE;
                mail_waiting = 1'b0;
                countdown_on = 1'b0;
            end
        endcase
        predicted.mail_present  = mail_waiting;
        predicted.link_state    = lnk_state;
        predicted.timer_running = countdown_on;
        return predicted;
    endfunction

    // ------------------------------------------------------------------------
    // Shared bookkeeping.
    // ------------------------------------------------------------------------
    evt_item_t pending_events[$];
    res_item_t awaited_results[$];
    int        errors         = 0;
    int        events_taken   = 0;
    int        results_seen   = 0;
    int        requests_seen  = 0;
    int        keepalives_seen = 0;
    int        quits_seen     = 0;
    int        bells_seen     = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Gap lengths for both channels: mostly none or short, a few long.
    function automatic int pick_pause(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Now and then a channel runs a long stretch with no idling at all.
    function automatic int next_calm(input int calm);
        if (calm > 0)
            return calm - 1;
        if ($urandom_range(0, 149) == 0)
            return 100;
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. An accepted transaction is stepped through the model at the
    // edge where it is taken; the next one is presented at the same edge,
    // unless a gap is due.
    // ------------------------------------------------------------------------
    int send_gap;
    int send_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid <= 1'b0;
            evt_data  <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (evt_valid && evt_ready)
            begin
                awaited_results.push_back(client_step(evt_data));
                events_taken++;
            end
            if (!evt_valid || evt_ready)
            begin
                if (send_gap != 0)
                begin
                    evt_valid <= 1'b0;
                    send_gap  <= send_gap - 1;
                end
                else if (pending_events.size() != 0)
                begin
                    evt_valid <= 1'b1;
                    evt_data  <= pending_events.pop_front();
                    send_calm  = next_calm(send_calm);
                    send_gap  <= pick_pause(send_calm != 0);
                end
                else
                    evt_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. It checks each result transaction against the oldest
    // prediction and throttles res_ready with random stalls.
    // ------------------------------------------------------------------------
    int        recv_stall;
    int        recv_calm = 0;
    res_item_t got_res;
    res_item_t want_res;

    task automatic check_field(input string field, input int unsigned got_v,
                               input int unsigned want_v);
        if (got_v != want_v)
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      results_seen, field, got_v, want_v));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                got_res = res_data;
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing awaited",
                                              results_seen));
                else
                begin
                    want_res = awaited_results.pop_front();
                    check_field("send_kind", 32'(got_res.send_kind),
                                32'(want_res.send_kind));
                    check_field("mail_present", 32'(got_res.mail_present),
                                32'(want_res.mail_present));
                    check_field("new_mail_bell", 32'(got_res.new_mail_bell),
                                32'(want_res.new_mail_bell));
                    check_field("link_state", 32'(got_res.link_state),
                                32'(want_res.link_state));
                    check_field("timer_running", 32'(got_res.timer_running),
                                32'(want_res.timer_running));
                    if (want_res.send_kind == SEND_REQ)
                        requests_seen++;
                    if (want_res.send_kind == SEND_KEEP)
                        keepalives_seen++;
                    if (want_res.send_kind == SEND_QUIT)
                        quits_seen++;
                    if (want_res.new_mail_bell)
                        bells_seen++;
                end
                results_seen++;
            end
            if (recv_stall != 0)
            begin
                res_ready  <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                res_ready  <= 1'b1;
                recv_calm   = next_calm(recv_calm);
                recv_stall <= pick_pause(recv_calm != 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog on forward progress.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_valid && evt_ready) || (res_valid && res_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles, %0d results awaited",
                         quiet_cycles, awaited_results.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus generation. Fields that an event does not use are filled at
    // random so that every input bit toggles.
    // ------------------------------------------------------------------------
    int          events_queued = 0;
    logic [31:0] gen_size = '0;
    logic [31:0] gen_date = '0;

    task automatic add_exact(input logic [1:0] cmd, input logic [2:0] kind,
                             input logic [15:0] ivl, input logic [31:0] size,
                             input logic [31:0] date, input logic [15:0] rnd);
        evt_item_t ev;
        ev.command       = cmd;
        ev.packet_kind   = kind;
        ev.interval_secs = ivl;
        ev.box_size      = size;
        ev.box_date      = date;
        ev.random_value  = rnd;
        pending_events.push_back(ev);
        events_queued++;
    endtask

    // Random values that hit zero and one waits as well as the full range.
    function automatic logic [15:0] pick_random_value();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'(UNIT * 2 / 3);
            2:       return 16'd1;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_interval();
        case ($urandom_range(0, 9))
            0:          return 16'd0;
            1, 2, 3:    return 16'($urandom_range(1, 12));
            4, 5, 6:    return 16'($urandom_range(20, 200));
            7:          return 16'($urandom_range(400, 1200));
            8:          return 16'hFFFF;
            default:    return 16'($urandom);
        endcase
    endfunction

    task automatic add_event(input logic [1:0] cmd, input logic [2:0] kind);
        add_exact(cmd, kind, 16'($urandom), $urandom, $urandom, pick_random_value());
    endtask

    task automatic add_registered();
        add_exact(CMD_PACKET, PKT_REGISTERED, pick_interval(), $urandom, $urandom,
                  pick_random_value());
    endtask

    // Mailbox reports that repeat, grow, refresh, empty or jump at random.
    task automatic add_status(input logic [2:0] kind);
        case ($urandom_range(0, 6))
            0: gen_size = '0;
            1: ;
            2: gen_size = gen_size + 32'($urandom_range(1, 1000));
            3: gen_date = gen_date + 32'($urandom_range(1, 1000));
            4: gen_size = 32'hFFFF_FFFF;
            5: gen_date = '0;
            default:
            begin
                gen_size = $urandom;
                gen_date = $urandom;
            end
        endcase
        add_exact(CMD_PACKET, kind, 16'($urandom), gen_size, gen_date, pick_random_value());
    endtask

    task automatic add_ticks(input int count);
        repeat (count) add_event(CMD_TICK, 3'($urandom_range(0, 7)));
    endtask

    task automatic add_noise();
        add_event(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
    endtask

    // A well-formed session: start, registration, status traffic and ticks,
    // with an occasional stray packet, then one of several endings.
    task automatic add_session();
        int steps;
        add_event(CMD_START, 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 11) == 0)
            add_event(CMD_PACKET, PKT_REFUSED);
        if ($urandom_range(0, 9) < 9)
            add_registered();
        else
            add_ticks($urandom_range(170, 190));
        steps = $urandom_range(2, 12);
        repeat (steps)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6:  add_status(PKT_STATUS);
                7, 8:                 add_status(PKT_BAD_STATUS);
                9, 10, 11, 12, 13:    add_ticks($urandom_range(1, 6));
                14:                   add_ticks($urandom_range(20, 130));
                15:                   add_registered();
                16:                   add_event(CMD_PACKET, 3'($urandom_range(0, 7)));
                default:              add_event(CMD_PACKET, PKT_OTHER);
            endcase
        end
        case ($urandom_range(0, 5))
            0, 1: add_event(CMD_END, 3'($urandom_range(0, 7)));
            2:    add_event(CMD_PACKET, PKT_QUIT);
            3:
            begin
                add_event(CMD_PACKET, PKT_QUIT_HUP);
                if ($urandom_range(0, 3) == 0)
                    add_ticks($urandom_range(360, 560));
                else
                    add_ticks($urandom_range(1, 10));
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        lnk_state         = ST_IDLE;
        countdown         = '0;
        countdown_on      = 1'b0;
        secs_since_status = '0;
        keepalive_ivl     = '0;
        last_box_size     = '0;
        last_box_date     = '0;
        mail_waiting      = 1'b0;

        // Directed part. Idle events first: a tick with the timer off, an end
        // that sends nothing, and a registration that nobody asked for.
        add_exact(CMD_TICK, PKT_QUIT_HUP, 16'h0000, 32'h0, 32'h0, 16'h0000);
        add_exact(CMD_END, PKT_UNDEFINED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_exact(CMD_PACKET, PKT_REGISTERED, 16'd5, 32'h0, 32'h0, 16'h0000);
        // A refusal goes idle but leaves the countdown running.
        add_exact(CMD_START, PKT_QUIT_HUP, 16'h0, 32'h0, 32'h0, 16'h0);
        add_exact(CMD_PACKET, PKT_REFUSED, 16'h0, 32'h0, 32'h0, 16'h0);
        add_exact(CMD_TICK, PKT_QUIT_HUP, 16'h0, 32'h0, 32'h0, 16'h0);
        // A zero keep-alive interval trips the watchdog on the first tick.
        add_exact(CMD_START, PKT_QUIT_HUP, 16'h0, 32'h0, 32'h0, 16'h0);
        add_exact(CMD_PACKET, PKT_REGISTERED, 16'h0000, 32'h0, 32'h0, 16'hFFFF);
        add_exact(CMD_TICK, PKT_QUIT_HUP, 16'h0, 32'h0, 32'h0, 16'h0);
        // Largest interval, then a status with a zero wait that fires on the
        // next tick and sends a keep-alive.
        add_exact(CMD_PACKET, PKT_REGISTERED, 16'hFFFF, 32'h0, 32'h0, 16'h0000);
        add_exact(CMD_PACKET, PKT_STATUS, 16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  16'(UNIT * 2 / 3));
        add_exact(CMD_TICK, PKT_QUIT_HUP, 16'h0, 32'h0, 32'h0, 16'h0);
        // A malformed status moves on without touching the mailbox history.
        add_exact(CMD_PACKET, PKT_BAD_STATUS, 16'h0, 32'h1234_5678, 32'h0, 16'd1);
        // An empty mailbox rings no bell and clears the mail flag.
        add_exact(CMD_PACKET, PKT_STATUS, 16'h0, 32'h0, 32'h0, 16'h0);
        // Bell by size, bell by date, then an unchanged mailbox.
        add_exact(CMD_PACKET, PKT_STATUS, 16'h0, 32'd5, 32'd0, 16'hFFFF);
        add_exact(CMD_PACKET, PKT_STATUS, 16'h0, 32'd5, 32'd1, 16'h0);
        add_exact(CMD_PACKET, PKT_STATUS, 16'h0, 32'd5, 32'd1, 16'd7);
        // Kinds that are never valid are ignored.
        add_exact(CMD_PACKET, PKT_OTHER, 16'h0, 32'h0, 32'h0, 16'h0);
        add_exact(CMD_PACKET, PKT_UNDEFINED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_exact(CMD_TICK, PKT_QUIT_HUP, 16'h0, 32'h0, 32'h0, 16'h0);
        // End from a live link sends quit.
        add_exact(CMD_END, PKT_QUIT_HUP, 16'h0, 32'h0, 32'h0, 16'h0);
        // Hang-up from the server, then an explicit quit.
        add_exact(CMD_START, PKT_QUIT_HUP, 16'h0, 32'h0, 32'h0, 16'h0);
        add_exact(CMD_PACKET, PKT_QUIT_HUP, 16'h0, 32'h0, 32'h0, 16'h0);
        add_exact(CMD_PACKET, PKT_QUIT, 16'h0, 32'h0, 32'h0, 16'hFFFF);
        add_exact(CMD_END, PKT_QUIT, 16'h0, 32'h0, 32'h0, 16'h0);

        // Random part: mostly sessions, some long tick runs that let every
        // kind of wait run out, and some noise.
        while (events_queued < RANDOM_EVENTS + 25)
        begin
            case ($urandom_range(0, 99))
                0, 1, 2: add_ticks($urandom_range(150, 560));
                3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20:
                    repeat ($urandom_range(1, 4)) add_noise();
                default: add_session();
            endcase
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_events.size() != 0 || evt_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d events and checked %0d results.", events_taken, results_seen);
        $display("Seen: %0d requests, %0d keep-alives, %0d quits, %0d new-mail bells.",
                 requests_seen, keepalives_seen, quits_seen, bells_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
